FILE: hw/rtl/mxd_pkg.sv
package mxd_pkg;

    typedef struct packed {
        logic [7:0] code_byte;
        logic [7:0] block_scale;
    } mxd_in_t;

    typedef struct packed {
        logic [15:0] bf16_bits;
        logic        domain_error;
    } mxd_out_t;

    localparam logic [7:0] ScaleInvalid = 8'd255;
    localparam logic [6:0] CodeNan      = 7'h7f;

endpackage

FILE: hw/rtl/mxd_convert.sv
// Combinational conversion of one E4M3 element and its E8M0 scale to bfloat16.
module mxd_convert
    import mxd_pkg::*;
(
    input  mxd_in_t  din,
    output mxd_out_t dout
);

    logic        sgn;
    logic [3:0]  ex4;
    logic [2:0]  man3;
    logic [3:0]  sig;
    logic [1:0]  top;
    logic signed [10:0] unb;
    logic [31:0] f32;
    logic [31:0] rnd;
    logic [4:0]  shamt;
    logic        err;

    always_comb
    begin
        sgn  = din.code_byte[7];
        ex4  = din.code_byte[6:3];
        man3 = din.code_byte[2:0];
        err  = (din.code_byte[6:0] == CodeNan) || (din.block_scale == ScaleInvalid);
        if (ex4 != 4'd0)
        begin
            sig = {1'b1, man3};
            top = 2'd3;
        end
        else
        begin
            sig = {1'b0, man3};
            top = man3[2] ? 2'd2 : (man3[1] ? 2'd1 : 2'd0);
        end
        // Unbiased exponent of the leading one: top + pw.
        if (ex4 != 4'd0)
            unb = $signed({7'd0, ex4}) - 11'sd10 + $signed({3'd0, din.block_scale})
                  - 11'sd127 + $signed({9'd0, top});
        else
            unb = -11'sd9 + $signed({3'd0, din.block_scale}) - 11'sd127
                  + $signed({9'd0, top});
        shamt = 5'd0;
        f32 = {sgn, 31'd0};
        if (sig != 4'd0)
        begin
            if (unb > 11'sd127)
                err = 1'b1;
            else if (unb >= -11'sd126)
            begin
                shamt = 5'(5'd23 - {3'd0, top});
                f32 = {sgn, 8'(unb + 11'sd127), 23'((32'(sig) << shamt))};
            end
            else
            begin
                // Float32 subnormal: shift is unb - top + 149.
                shamt = 5'(unb - $signed({9'd0, top}) + 11'sd149);
                f32 = {sgn, 31'(32'(sig) << shamt)};
            end
        end
        rnd = (f32 + 32'h7fff + {31'd0, f32[16]}) & 32'hffff0000;
        if (rnd[30:23] == 8'hff)
            err = 1'b1;
        dout.domain_error = err;
        dout.bf16_bits    = err ? 16'd0 : rnd[31:16];
    end

endmodule

FILE: hw/rtl/mx_e4m3_to_bf16_decode.sv
// An accepted input word is converted and its result sits in the output register in the next cycle.
// Throughput: one word per cycle; the output register holds a result while the
// sink stalls, and a new word is taken whenever that register is empty or drains.
// Reset: rst_n is asynchronous and active low; it empties the output register.
// The conversion itself holds no state.
module mx_e4m3_to_bf16_decode
    import mxd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  mxd_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output mxd_out_t out_data
);

    mxd_out_t conv;
    mxd_out_t data_reg;
    logic     valid_reg;

    // The whole conversion fits between the input port and the result register.
    mxd_convert u_convert (
        .din  (in_data),
        .dout (conv)
    );

    // Accept whenever the result register is empty or is being read this cycle.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= conv;
    end

    // An error result always carries a zero pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.domain_error |-> data_reg.bf16_bits == 16'd0)
        else $error("error result with non-zero pattern");

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("stalled result changed");

    // An accepted word always appears in the result register next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg)
        else $error("accepted word lost");

endmodule

FILE: sim/mx_e4m3_to_bf16_decode_tb.sv
module mx_e4m3_to_bf16_decode_tb
    import mxd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 2000;
    localparam int RandomWords   = 1800;
    localparam int DrainCycles   = 8;

    // Predicts the decoded bfloat16 word for each accepted element and checks
    // the block's results against those predictions in order.
    class bf16_scoreboard;
        mxd_out_t pending[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // Exact decode of E4M3 times 2^(scale-127) into float32, then
        // round-to-nearest-even down to bfloat16.
        function mxd_out_t decode(mxd_in_t w);
            mxd_out_t    r;
            logic        sgn;
            logic [3:0]  ex4;
            logic [2:0]  man3;
            logic [3:0]  sig;
            int          pw;
            int          msb;
            int          unb;
            logic [31:0] f32;
            logic [31:0] rnd;
            sgn  = w.code_byte[7];
            ex4  = w.code_byte[6:3];
            man3 = w.code_byte[2:0];
            r.bf16_bits    = 16'h0000;
            r.domain_error = 1'b1;
            if (w.code_byte[6:0] == CodeNan || w.block_scale == ScaleInvalid)
                return r;
            if (ex4 != 4'd0)
            begin
                sig = {1'b1, man3};
                pw  = int'(ex4) - 10;
            end
            else
            begin
                sig = {1'b0, man3};
                pw  = -9;
            end
            pw = pw + int'(w.block_scale) - 127;
            if (sig == 4'd0)
                f32 = {sgn, 31'd0};
            else
            begin
                msb = sig[3] ? 3 : sig[2] ? 2 : sig[1] ? 1 : 0;
                unb = msb + pw;
                if (unb > 127)
                    return r;
                if (unb >= -126)
                    f32 = {sgn, 8'(unb + 127), 23'((32'(sig) << (23 - msb)) & 32'h7fffff)};
                else
                    f32 = {sgn, 31'(32'(sig) << (pw + 149))};
            end
            rnd = (f32 + 32'h7fff + {31'd0, f32[16]}) & 32'hffff0000;
            if (rnd[30:23] == 8'hff)
                return r;
            r.bf16_bits    = rnd[31:16];
            r.domain_error = 1'b0;
            return r;
        endfunction

        function void note_element(mxd_in_t w);
            pending.push_back(decode(w));
        endfunction

        function void check_word(mxd_out_t got);
            mxd_out_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word, actual %h/%b", $time,
                         got.bf16_bits, got.domain_error);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.bf16_bits !== want.bf16_bits)
            begin
                $display("%0t: bf16_bits expected %h actual %h", $time,
                         want.bf16_bits, got.bf16_bits);
                errors++;
            end
            if (got.domain_error !== want.domain_error)
            begin
                $display("%0t: domain_error expected %b actual %b", $time,
                         want.domain_error, got.domain_error);
                errors++;
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    mxd_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    mxd_out_t out_data;

    // Percentages of cycles in which the source holds back and the sink stalls.
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int          quiet_cycles;
    bf16_scoreboard decoded;

    mx_e4m3_to_bf16_decode dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        decoded        = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    end

    // The sink draws a fresh stall decision every cycle; results are sampled at
    // the edge itself, before the nonblocking updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                decoded.check_word(out_data);
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // The watchdog counts cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("FAIL mx_e4m3_to_bf16_decode");
            $finish;
        end
    end

    // Offers one element, with random idle cycles before it, and waits until
    // the block takes it. Valid stays high from one word straight to the next unless idle cycles are drawn.
    task automatic send_element(input logic [7:0] code, input logic [7:0] scale);
        mxd_in_t w;
        w.code_byte   = code;
        w.block_scale = scale;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decoded.note_element(w);
    endtask

    task automatic release_source();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Codes and scales are uniform in half of the words; the other half is steered towards the
    // float32 subnormal band, the overflow edge and the NaN code.
    task automatic send_random(input int count);
        logic [7:0] code;
        logic [7:0] scale;
        for (int i = 0; i < count; i++)
        begin
            code = 8'($urandom);
            case ($urandom_range(5))
                0: scale = 8'($urandom_range(20));
                1: scale = 8'($urandom_range(254, 235));
                2: code  = {code[7], CodeNan};
                default: scale = 8'($urandom);
            endcase
            if ($urandom_range(3) != 0 && code[6:0] == CodeNan)
                code[0] = 1'b0;
            send_element(code, scale);
        end
        release_source();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: both zeros, subnormal and largest codes, both NaN
        // codes, the invalid scale, the smallest and largest scales, and scales just
        // past the overflow edge at the top of the range.
        send_element(8'h00, 8'd127);
        send_element(8'h80, 8'd127);
        send_element(8'h01, 8'd127);
        send_element(8'h87, 8'd0);
        send_element(8'h01, 8'd0);
        send_element(8'h7e, 8'd0);
        send_element(8'h7e, 8'd254);
        send_element(8'hfe, 8'd254);
        send_element(8'h7f, 8'd127);
        send_element(8'hff, 8'd127);
        send_element(8'h38, 8'd255);
        send_element(8'h00, 8'd255);
        send_element(8'h7e, 8'd247);
        send_element(8'h7d, 8'd247);
        send_element(8'h7e, 8'd248);
        send_element(8'h40, 8'd127);
        send_element(8'h05, 8'd2);
        send_element(8'h0f, 8'd3);
        send_element(8'haa, 8'd55);
        send_element(8'h55, 8'd170);
        release_source();

        src_idle_pct   = 19;
        sink_stall_pct = 52;
        send_random(RandomWords / 3);
        src_idle_pct   = 52;
        sink_stall_pct = 19;
        send_random(RandomWords / 3);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_random(RandomWords / 3);

        while (decoded.pending.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (decoded.errors == 0)
            $display("PASS mx_e4m3_to_bf16_decode");
        else
            $display("FAIL mx_e4m3_to_bf16_decode");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/mxd_pkg.sv
hw/rtl/mxd_convert.sv
hw/rtl/mx_e4m3_to_bf16_decode.sv
sim/mx_e4m3_to_bf16_decode_tb.sv
